@@ rtl/dsm_pkg.sv @@
// Shared types, register codes and reset values for the debounced sensor matrix.
// No dependencies; every other file but dsm_ram refers to it by scoped names.

package dsm_pkg;

    localparam int DEF_ROWS = 8;
    localparam int DEF_COLS = 8;

    localparam int AXIS_W  = 3;
    localparam int STAMP_W = 32;
    localparam int DEB_W   = 16;
    localparam int MAP_W   = 24;

    // one cell entry in RAM: stable bit, raw bit and change stamp
    localparam int ENTRY_W = STAMP_W + 2;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_AXES     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_MAP       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COL_MAP       = 8'd3;

    localparam logic [DEB_W-1:0] RST_DEBOUNCE_TIME = 16'd50;
    localparam logic [MAP_W-1:0] RST_MAP           = 24'hFAC688;

    typedef struct packed {
        logic [DEB_W-1:0] debounce_time;
        logic             swap_axes;
        logic [MAP_W-1:0] row_map;
        logic [MAP_W-1:0] col_map;
    } cfg_t;

    // one sample after remapping, held between the input side and the cell update
    typedef struct packed {
        logic [AXIS_W-1:0]  cell_row;
        logic [AXIS_W-1:0]  cell_col;
        logic               in_range;
        logic               pressed;
        logic [STAMP_W-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic               stable;
        logic               raw;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic [AXIS_W-1:0] cell_row;
        logic [AXIS_W-1:0] cell_col;
        logic              stable_state;
        logic              state_changed;
    } res_t;

endpackage

@@ rtl/dsm_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Read returns the old contents when the same address is written in that cycle.

module dsm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/dsm_remap.sv @@
// Physical-to-logical position remap: optional axis swap, then two 8-entry tables.
// Also flags positions outside the matrix and forms the cell index. Uses dsm_pkg.

module dsm_remap #(
    parameter int ROWS   = dsm_pkg::DEF_ROWS,
    parameter int COLS   = dsm_pkg::DEF_COLS,
    parameter int CELL_W = $clog2(ROWS * COLS)
) (
    input  dsm_pkg::cfg_t                   cfg,
    input  logic [dsm_pkg::AXIS_W-1:0]      phys_row,
    input  logic [dsm_pkg::AXIS_W-1:0]      phys_col,
    output logic [dsm_pkg::AXIS_W-1:0]      cell_row,
    output logic [dsm_pkg::AXIS_W-1:0]      cell_col,
    output logic                            in_range,
    output logic [CELL_W-1:0]               cell_idx
);

    logic [dsm_pkg::AXIS_W-1:0] row_sel;
    logic [dsm_pkg::AXIS_W-1:0] col_sel;

    always_comb
    begin
        row_sel  = cfg.swap_axes ? phys_col : phys_row;
        col_sel  = cfg.swap_axes ? phys_row : phys_col;
        cell_row = cfg.row_map[3 * row_sel +: dsm_pkg::AXIS_W];
        cell_col = cfg.col_map[3 * col_sel +: dsm_pkg::AXIS_W];
        in_range = ({1'b0, cell_row} < 4'(ROWS)) && ({1'b0, cell_col} < 4'(COLS));
        // park outside positions on cell zero; nothing is written for them
        cell_idx = in_range ? CELL_W'(int'(cell_row) * COLS + int'(cell_col)) : '0;
    end

endmodule

@@ rtl/dsm_cell.sv @@
// Per-cell entry valid bits and debounce update logic.
// Entries come from the external cell RAM or the forward path, else read as zero. Uses dsm_pkg.

module dsm_cell #(
    parameter int ROWS   = dsm_pkg::DEF_ROWS,
    parameter int COLS   = dsm_pkg::DEF_COLS,
    parameter int CELL_W = $clog2(ROWS * COLS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic [CELL_W-1:0]             rd_idx,
    input  logic                          advance,
    input  dsm_pkg::item_t                item,
    input  logic [CELL_W-1:0]             cell_idx,
    input  logic [dsm_pkg::DEB_W-1:0]     debounce_time,
    input  dsm_pkg::entry_t               ram_entry,
    input  logic                          fwd_hit,
    input  dsm_pkg::entry_t               fwd_entry,
    output logic                          entry_wr_en,
    output dsm_pkg::entry_t               entry_wr_data,
    output dsm_pkg::res_t                 res
);

    localparam int CELLS = ROWS * COLS;

    logic [CELLS-1:0] entry_valid_reg;
    logic [CELLS-1:0] entry_valid_next;
    logic             known_reg;

    dsm_pkg::entry_t             cur;
    logic                        stable_new;
    logic                        raw_new;
    logic                        restart;
    logic [dsm_pkg::STAMP_W-1:0] elapsed;

    always_comb
    begin
        // a never-written entry reads as zero; a forwarded write at the edge of the read wins
        if (fwd_hit)
        begin
            cur = fwd_entry;
        end
        else if (known_reg)
        begin
            cur = ram_entry;
        end
        else
        begin
            cur = '0;
        end
        elapsed = item.now_ms - cur.stamp;

        stable_new = cur.stable;
        raw_new    = cur.raw;
        restart    = 1'b0;
        if (item.pressed != cur.stable)
        begin
            if (item.pressed != cur.raw)
            begin
                raw_new = item.pressed;
                restart = 1'b1;
            end
            else if (elapsed >= {16'd0, debounce_time})
            begin
                stable_new = item.pressed;
            end
        end
        else
        begin
            raw_new = item.pressed;
            restart = 1'b1;
        end

        entry_wr_en          = advance && item.in_range;
        entry_wr_data.stable = stable_new;
        entry_wr_data.raw    = raw_new;
        entry_wr_data.stamp  = restart ? item.now_ms : cur.stamp;

        entry_valid_next = entry_valid_reg;
        if (entry_wr_en)
        begin
            entry_valid_next[cell_idx] = 1'b1;
        end

        res.cell_row      = item.cell_row;
        res.cell_col      = item.cell_col;
        res.stable_state  = item.in_range && stable_new;
        res.state_changed = item.in_range && (stable_new != cur.stable);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
        end
        else
        begin
            entry_valid_reg <= entry_valid_next;
        end
    end

    // look up the valid bit alongside the RAM read
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            known_reg <= entry_valid_reg[rd_idx];
        end
    end

endmodule

@@ rtl/debounced_sensor_matrix.sv @@
// Top level of the debounced sensor matrix: config registers, sample stage,
// cell RAM, forward path and output register. Uses dsm_pkg, dsm_remap, dsm_cell, dsm_ram.
//
// Usage:
//   s_axis carries one scanned sample per transaction; m_axis returns exactly one
//   result per sample, in order. cfg writes one register (index 0 debounce_time,
//   1 swap_axes, 2 row_map, 3 col_map; other indexes are dropped); write it only
//   while no sample is in flight. cfg_ready is always high.
//   A sample passes the stage and output registers to m_axis_tvalid. Throughput
//   is one sample per cycle unless the receiver stalls: the remap and the cell
//   RAM read happen at acceptance, the per-cell read-modify-write when the sample
//   leaves the stage, with a one-entry forward register covering an entry written
//   at the same edge as the read. When the receiver stalls, the result holds in
//   the output register while the next sample is still taken into the stage;
//   s_axis_tready drops only when both are full. Reset clears all cell state at
//   once (per-cell valid bits stand in for zeroed entries), restores the register
//   defaults and empties the pipeline; no clearing pass is needed.

module debounced_sensor_matrix #(
    parameter int ROWS = dsm_pkg::DEF_ROWS,
    parameter int COLS = dsm_pkg::DEF_COLS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // phys_row [2:0], phys_col [5:3], pressed [6], now_ms [38:7], zero [39]
    input  logic [dsm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // cell_row [2:0], cell_col [5:3], stable_state [6], state_changed [7]
    output logic [dsm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dsm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dsm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CELLS  = ROWS * COLS;
    localparam int CELL_W = $clog2(CELLS);

    dsm_pkg::cfg_t cfg_reg;

    logic                          s_fire;
    logic                          advance;
    logic                          m_fire;

    logic [dsm_pkg::AXIS_W-1:0]    in_row;
    logic [dsm_pkg::AXIS_W-1:0]    in_col;
    logic                          in_range;
    logic [CELL_W-1:0]             in_idx;

    logic                          stage_valid_reg;
    logic                          stage_valid_next;
    dsm_pkg::item_t                stage_item_reg;
    logic [CELL_W-1:0]             stage_idx_reg;

    logic                          fwd_hit_reg;
    dsm_pkg::entry_t               fwd_entry_reg;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    dsm_pkg::res_t                 out_res_reg;

    logic                          entry_wr_en;
    dsm_pkg::entry_t               entry_wr_data;
    dsm_pkg::entry_t               ram_entry;
    dsm_pkg::res_t                 res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time <= dsm_pkg::RST_DEBOUNCE_TIME;
            cfg_reg.swap_axes     <= 1'b0;
            cfg_reg.row_map       <= dsm_pkg::RST_MAP;
            cfg_reg.col_map       <= dsm_pkg::RST_MAP;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dsm_pkg::REG_DEBOUNCE_TIME: cfg_reg.debounce_time <= cfg_data[15:0];
                dsm_pkg::REG_SWAP_AXES:     cfg_reg.swap_axes     <= cfg_data[0];
                dsm_pkg::REG_ROW_MAP:       cfg_reg.row_map       <= cfg_data;
                dsm_pkg::REG_COL_MAP:       cfg_reg.col_map       <= cfg_data;
                default:                    ;
            endcase
        end
    end

    dsm_remap #(
        .ROWS   (ROWS),
        .COLS   (COLS),
        .CELL_W (CELL_W)
    ) u_remap (
        .cfg      (cfg_reg),
        .phys_row (s_axis_tdata[2:0]),
        .phys_col (s_axis_tdata[5:3]),
        .cell_row (in_row),
        .cell_col (in_col),
        .in_range (in_range),
        .cell_idx (in_idx)
    );

    assign m_fire        = out_valid_reg && m_axis_tready;
    assign advance       = stage_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !stage_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (s_fire)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            stage_item_reg.cell_row <= in_row;
            stage_item_reg.cell_col <= in_col;
            stage_item_reg.in_range <= in_range;
            stage_item_reg.pressed  <= s_axis_tdata[6];
            stage_item_reg.now_ms   <= s_axis_tdata[38:7];
            stage_idx_reg           <= in_idx;
            // the RAM read at this edge misses an entry written at the same edge
            fwd_hit_reg             <= entry_wr_en && (stage_idx_reg == in_idx);
            fwd_entry_reg           <= entry_wr_data;
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    dsm_ram #(
        .WIDTH  (dsm_pkg::ENTRY_W),
        .DEPTH  (CELLS),
        .ADDR_W (CELL_W)
    ) u_cell_ram (
        .clk     (clk),
        .wr_en   (entry_wr_en),
        .wr_addr (stage_idx_reg),
        .wr_data (entry_wr_data),
        .rd_en   (s_fire),
        .rd_addr (in_idx),
        .rd_data (ram_entry)
    );

    dsm_cell #(
        .ROWS   (ROWS),
        .COLS   (COLS),
        .CELL_W (CELL_W)
    ) u_cell (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (s_fire),
        .rd_idx        (in_idx),
        .advance       (advance),
        .item          (stage_item_reg),
        .cell_idx      (stage_idx_reg),
        .debounce_time (cfg_reg.debounce_time),
        .ram_entry     (ram_entry),
        .fwd_hit       (fwd_hit_reg),
        .fwd_entry     (fwd_entry_reg),
        .entry_wr_en   (entry_wr_en),
        .entry_wr_data (entry_wr_data),
        .res           (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.state_changed, out_res_reg.stable_state,
                            out_res_reg.cell_col, out_res_reg.cell_row};

endmodule

@@ rtl/dsm_checker.sv @@
// Port-level checks for the debounced sensor matrix, attached by bind.
// Uses dsm_pkg for port widths.

module dsm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [dsm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [dsm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [dsm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [dsm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

    // a fresh result comes from a sample accepted into the stage register before it
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching sample");

    // with the output register empty the input side never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

    // after an accepted sample has passed the stage register, m_axis_tvalid is high
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
    else $error("accepted sample produced no result");

endmodule

bind debounced_sensor_matrix dsm_checker u_dsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
);
